// ===== hw/rtl/itk_pkg.sv =====
// itk_pkg: shared types, codes and constants for the IRC line tokenizer.
// No dependencies; imported by every itk_* module and the top level.
package itk_pkg;

   // Field widths
   localparam int ByteW   = 8;
   localparam int LenW    = 13;
   localparam int ParW    = 5;
   localparam int ClassW  = 3;
   localparam int ErrW    = 4;

   // Configuration register indexes and reset values
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_LINE_LENGTH = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_MAX_PARAMS      = 1'b1;
   localparam logic [LenW-1:0] MaxLineLengthReset = 13'd512;
   localparam logic [ParW-1:0] MaxParamsReset     = 5'd15;

   // Saturation limits
   localparam logic [LenW-1:0] CountMax = {LenW{1'b1}};
   localparam logic [ParW-1:0] ParSat   = {ParW{1'b1}};

   // Default depth of the queue between front and back
   localparam int QueueDepthDefault = 4;

   // Characters of interest
   localparam logic [ByteW-1:0] CHAR_CR    = 8'h0D;
   localparam logic [ByteW-1:0] CHAR_SPACE = 8'h20;
   localparam logic [ByteW-1:0] CHAR_COLON = 8'h3A;
   localparam logic [ByteW-1:0] CHAR_NUL   = 8'h00;

   // Byte classes
   localparam logic [ClassW-1:0] CLS_SPACE     = 3'd0;
   localparam logic [ClassW-1:0] CLS_COLON     = 3'd1;
   localparam logic [ClassW-1:0] CLS_PREFIX    = 3'd2;
   localparam logic [ClassW-1:0] CLS_COMMAND   = 3'd3;
   localparam logic [ClassW-1:0] CLS_MIDDLE    = 3'd4;
   localparam logic [ClassW-1:0] CLS_TRAILING  = 3'd5;
   localparam logic [ClassW-1:0] CLS_CR        = 3'd6;
   localparam logic [ClassW-1:0] CLS_AFTER_ERR = 3'd7;

   // Error codes
   localparam logic [ErrW-1:0] ERR_NONE         = 4'd0;
   localparam logic [ErrW-1:0] ERR_TOO_LONG     = 4'd1;
   localparam logic [ErrW-1:0] ERR_NUL          = 4'd2;
   localparam logic [ErrW-1:0] ERR_BLANK        = 4'd3;
   localparam logic [ErrW-1:0] ERR_PFX_NO_SPACE = 4'd4;
   localparam logic [ErrW-1:0] ERR_EMPTY_PFX    = 4'd5;
   localparam logic [ErrW-1:0] ERR_EMPTY_CMD    = 4'd6;
   localparam logic [ErrW-1:0] ERR_BAD_CMD      = 4'd7;
   localparam logic [ErrW-1:0] ERR_TOO_MANY     = 4'd8;

   typedef struct packed {
      logic [ByteW-1:0] byte_value;
      logic             last_byte;
   } itk_req_type;

   typedef struct packed {
      logic [ClassW-1:0] byte_class;
      logic [ParW-1:0]   param_index;
      logic              line_done;
      logic              line_valid;
      logic [ErrW-1:0]   error_code;
      logic [ParW-1:0]   param_count;
      logic              has_trailing;
   } itk_rsp_type;

   // Classified byte as it travels from front to back
   typedef struct packed {
      logic last_byte;
      logic is_space;
      logic is_colon;
      logic is_cr;
      logic is_nul;
      logic is_alnum;
   } itk_tok_type;

endpackage

// ===== hw/rtl/itk_front.sv =====
// itk_front: accepts input bytes and classifies them for the parser.
// Depends on itk_pkg.
module itk_front import itk_pkg::*; (
   input  logic        req_valid,
   input  itk_req_type req_data,
   input  logic        queue_full,
   output logic        req_stall,
   output logic        push_valid,
   output itk_tok_type push_tok
);

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   always_comb begin
      push_tok.last_byte = req_data.last_byte;
      push_tok.is_space  = (req_data.byte_value == CHAR_SPACE);
      push_tok.is_colon  = (req_data.byte_value == CHAR_COLON);
      push_tok.is_cr     = (req_data.byte_value == CHAR_CR);
      push_tok.is_nul    = (req_data.byte_value == CHAR_NUL);
      push_tok.is_alnum  = req_data.byte_value inside {[8'h41:8'h5A], [8'h61:8'h7A],
                                                       [8'h30:8'h39]};
   end

endmodule

// ===== hw/rtl/itk_queue.sv =====
// itk_queue: short register queue between the classifier and the parser.
// Depends on itk_pkg.
module itk_queue import itk_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  itk_tok_type push_tok,
   input  logic        pop,
   output logic        full,
   output logic        head_valid,
   output itk_tok_type head_tok
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

   itk_tok_type           mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = (count_ff == DepthCnt);
   assign head_valid = (count_ff != '0);
   assign head_tok   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCnt)
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");
`endif

endmodule

// ===== hw/rtl/itk_back.sv =====
// itk_back: line phase machine, error tracking and result register.
// Depends on itk_pkg; fed from itk_queue.
module itk_back import itk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [LenW-1:0]   max_line_length,
   input  logic [ParW-1:0]   max_params,
   input  logic              head_valid,
   input  itk_tok_type       head_tok,
   output logic              pop,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output itk_rsp_type       rsp_data
);

   localparam logic [2:0] PH_LEAD    = 3'd0;
   localparam logic [2:0] PH_PREFIX  = 3'd1;
   localparam logic [2:0] PH_AFTPFX  = 3'd2;
   localparam logic [2:0] PH_CMD     = 3'd3;
   localparam logic [2:0] PH_PARAMSP = 3'd4;
   localparam logic [2:0] PH_MIDDLE  = 3'd5;
   localparam logic [2:0] PH_TRAIL   = 3'd6;

   localparam int TotW = ParW + 2;

   logic [2:0]      phase_ff, phase_in;
   logic [LenW-1:0] count_ff, count_in;
   logic [ErrW-1:0] err_ff, err_in;
   logic [ParW-1:0] total_ff, total_in;
   logic [ParW-1:0] cur_ff, cur_in;
   logic            nul_ff, nul_in;
   logic            pfx_ne_ff, pfx_ne_in;
   logic            trl_ff, trl_in;
   logic            trl_ne_ff, trl_ne_in;
   logic            over_ff, over_in;
   logic            rsp_valid_ff, rsp_valid_in;
   itk_rsp_type     rsp_ff, rsp_in;
   logic            too_long;
   logic [TotW-1:0] total_w;

   assign pop       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      phase_in  = phase_ff;
      err_in    = err_ff;
      total_in  = total_ff;
      cur_in    = cur_ff;
      pfx_ne_in = pfx_ne_ff;
      trl_in    = trl_ff;
      trl_ne_in = trl_ne_ff;
      over_in   = over_ff;
      count_in  = (count_ff != CountMax) ? count_ff + 1'b1 : count_ff;
      nul_in    = nul_ff | head_tok.is_nul;
      too_long  = (count_in > max_line_length);
      total_w   = '0;
      rsp_in    = '0;
      rsp_in.byte_class = CLS_SPACE;

      if (too_long || nul_in || (err_ff != ERR_NONE)) begin
         rsp_in.byte_class = CLS_AFTER_ERR;
      end else if (head_tok.last_byte && head_tok.is_cr) begin
         rsp_in.byte_class = CLS_CR;
      end else begin
         case (phase_ff)
            PH_LEAD, PH_AFTPFX, PH_CMD: begin
               if (head_tok.is_space) begin
                  rsp_in.byte_class = CLS_SPACE;
                  if (phase_ff == PH_CMD) begin
                     phase_in = PH_PARAMSP;
                  end
               end else if (head_tok.is_colon && phase_ff == PH_LEAD) begin
                  rsp_in.byte_class = CLS_COLON;
                  phase_in  = PH_PREFIX;
                  pfx_ne_in = 1'b0;
               end else begin
                  // command byte, first or continuing
                  rsp_in.byte_class = CLS_COMMAND;
                  phase_in = PH_CMD;
                  if (!head_tok.is_alnum && err_in == ERR_NONE) begin
                     err_in = ERR_BAD_CMD;
                  end
               end
            end
            PH_PREFIX: begin
               if (head_tok.is_space) begin
                  rsp_in.byte_class = CLS_SPACE;
                  phase_in = PH_AFTPFX;
                  if (!pfx_ne_ff && err_in == ERR_NONE) begin
                     err_in = ERR_EMPTY_PFX;
                  end
               end else begin
                  rsp_in.byte_class = CLS_PREFIX;
                  pfx_ne_in = 1'b1;
               end
            end
            PH_PARAMSP: begin
               if (head_tok.is_space) begin
                  rsp_in.byte_class = CLS_SPACE;
               end else if (head_tok.is_colon) begin
                  rsp_in.byte_class = CLS_COLON;
                  trl_in   = 1'b1;
                  phase_in = PH_TRAIL;
               end else begin
                  // new middle parameter; index saturates
                  if (total_ff == ParSat) begin
                     over_in = 1'b1;
                  end else begin
                     total_in = total_ff + 1'b1;
                  end
                  cur_in   = total_ff;
                  phase_in = PH_MIDDLE;
                  rsp_in.byte_class  = CLS_MIDDLE;
                  rsp_in.param_index = total_ff;
               end
            end
            PH_MIDDLE: begin
               if (head_tok.is_space) begin
                  rsp_in.byte_class = CLS_SPACE;
                  phase_in = PH_PARAMSP;
               end else begin
                  rsp_in.byte_class  = CLS_MIDDLE;
                  rsp_in.param_index = cur_ff;
               end
            end
            default: begin
               rsp_in.byte_class = CLS_TRAILING;
               trl_ne_in = 1'b1;
            end
         endcase
      end

      if (head_tok.last_byte) begin
         total_w = TotW'(total_in) + TotW'(trl_ne_in) + TotW'(over_in);
         if (err_in == ERR_NONE) begin
            case (phase_in)
               PH_LEAD:   err_in = ERR_BLANK;
               PH_PREFIX: err_in = ERR_PFX_NO_SPACE;
               PH_AFTPFX: err_in = ERR_EMPTY_CMD;
               PH_CMD:    err_in = ERR_NONE;
               default: begin
                  if (total_w > TotW'(max_params)) begin
                     err_in = ERR_TOO_MANY;
                  end
               end
            endcase
         end
         if (too_long) begin
            rsp_in.error_code = ERR_TOO_LONG;
         end else if (nul_in) begin
            rsp_in.error_code = ERR_NUL;
         end else begin
            rsp_in.error_code = err_in;
         end
         rsp_in.line_done    = 1'b1;
         rsp_in.line_valid   = (rsp_in.error_code == ERR_NONE);
         rsp_in.param_count  = (total_w > TotW'(ParSat)) ? ParSat : total_w[ParW-1:0];
         rsp_in.has_trailing = trl_in;
         // start over for the next line
         phase_in  = PH_LEAD;
         count_in  = '0;
         err_in    = ERR_NONE;
         total_in  = '0;
         cur_in    = '0;
         nul_in    = 1'b0;
         pfx_ne_in = 1'b0;
         trl_in    = 1'b0;
         trl_ne_in = 1'b0;
         over_in   = 1'b0;
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         count_ff     <= '0;
         err_ff       <= ERR_NONE;
         total_ff     <= '0;
         cur_ff       <= '0;
         nul_ff       <= 1'b0;
         pfx_ne_ff    <= 1'b0;
         trl_ff       <= 1'b0;
         trl_ne_ff    <= 1'b0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            err_ff    <= err_in;
            total_ff  <= total_in;
            cur_ff    <= cur_in;
            nul_ff    <= nul_in;
            pfx_ne_ff <= pfx_ne_in;
            trl_ff    <= trl_in;
            trl_ne_ff <= trl_ne_in;
            over_ff   <= over_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_valid_matches_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.line_done) |->
         (rsp_ff.line_valid == (rsp_ff.error_code == ERR_NONE)))
      else $error("line_valid disagrees with error_code");

   a_quiet_midline: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.line_done) |->
         (rsp_ff.error_code == ERR_NONE && rsp_ff.param_count == '0 &&
          !rsp_ff.has_trailing && !rsp_ff.line_valid))
      else $error("line summary shown before the last byte");

   a_restart_after_line: assert property (@(posedge clock) disable iff (reset)
      (pop && head_tok.last_byte) |=>
         (phase_ff == PH_LEAD && count_ff == '0 && err_ff == ERR_NONE &&
          total_ff == '0 && !nul_ff))
      else $error("parser did not start over after a line");
`endif

endmodule

// ===== hw/rtl/irc_line_tokenizer.sv =====
// irc_line_tokenizer: top level of the streaming IRC line tokenizer.
// Depends on itk_pkg, itk_front, itk_queue and itk_back.
//
//   channel  dir   handshake              payload
//   req_     in    req_valid / req_stall  itk_req_type (byte_value, last_byte)
//   rsp_     out   rsp_valid / rsp_stall  itk_rsp_type (one per input byte)
//   csr_     in    csr_valid / csr_ready  csr_index, csr_wdata
//
// One byte per cycle sustained while rsp_stall is low; a byte's result
// passes the queue write, then the parser step into the rsp reg, before
// it is valid. The rate is set by the phase step in itk_back.
// Reset is synchronous, active high; it restores the register defaults
// (line length 512, 15 params) and starts a fresh line.
// req_stall rises only when the front/back queue is full; rsp_stall
// holds the result register and lets the queue soak up incoming bytes.
module irc_line_tokenizer import itk_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   // input bytes
   input  logic               req_valid,
   output logic               req_stall,
   input  itk_req_type        req_data,
   // results
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output itk_rsp_type        rsp_data,
   // configuration writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [LenW-1:0]    csr_wdata
);

   logic [LenW-1:0] max_len_ff, max_len_in;
   logic [ParW-1:0] max_par_ff, max_par_in;

   logic            queue_full;
   logic            push_valid;
   itk_tok_type     push_tok;
   logic            head_valid;
   itk_tok_type     head_tok;
   logic            pop;

   // All writes are taken; software must write only while the block is idle.
   assign csr_ready = 1'b1;

   always_comb begin
      max_len_in = max_len_ff;
      max_par_in = max_par_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_LINE_LENGTH: max_len_in = csr_wdata;
            CSR_MAX_PARAMS:      max_par_in = csr_wdata[ParW-1:0];
            default: begin
               max_len_in = max_len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxLineLengthReset;
         max_par_ff <= MaxParamsReset;
      end else begin
         max_len_ff <= max_len_in;
         max_par_ff <= max_par_in;
      end
   end

   // Front: accept and classify each byte
   itk_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push_valid (push_valid),
      .push_tok   (push_tok)
   );

   // Short queue decoupling classifier from parser
   itk_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_tok   (push_tok),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_tok   (head_tok)
   );

   // Back: phase machine and result register
   itk_back u_back (
      .clock           (clock),
      .reset           (reset),
      .max_line_length (max_len_ff),
      .max_params      (max_par_ff),
      .head_valid      (head_valid),
      .head_tok        (head_tok),
      .pop             (pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data)
   );

endmodule

// ===== tb/itk_token_checker.sv =====
// itk_token_checker: watches the byte, result and register channels of the
// IRC line tokenizer, predicts each result and compares it field by field.
// Depends on itk_pkg for the payload types, byte classes and error codes.
module itk_token_checker import itk_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  itk_req_type        req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  itk_rsp_type        rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [LenW-1:0]    csr_wdata,
   output int                 mismatches,
   output int                 tokens_waiting
);

   typedef enum logic [2:0] {
      LN_LEAD, LN_PREFIX, LN_AFTER_PREFIX, LN_COMMAND, LN_PARAM_GAP, LN_MIDDLE, LN_TRAILING
   } line_phase_type;

   // limits as last written
   logic [LenW-1:0] lim_len;
   logic [ParW-1:0] lim_params;

   // per-line parse state
   line_phase_type  phase;
   logic [LenW-1:0] len_count;
   logic [ErrW-1:0] first_err;
   logic [ParW-1:0] started_params;
   logic [ParW-1:0] cur_param;
   logic            param_over;
   logic            saw_nul;
   logic            pfx_filled;
   logic            trail_seen;
   logic            trail_filled;

   itk_rsp_type predicted_tokens[$];
   int          token_seq;

   task automatic clear_line_state();
      phase          = LN_LEAD;
      len_count      = '0;
      first_err      = ERR_NONE;
      started_params = '0;
      cur_param      = '0;
      param_over     = 1'b0;
      saw_nul        = 1'b0;
      pfx_filled     = 1'b0;
      trail_seen     = 1'b0;
      trail_filled   = 1'b0;
   endtask

   task automatic note_error(input logic [ErrW-1:0] code);
      if (first_err == ERR_NONE) first_err = code;
   endtask

   function automatic logic is_alnum(input logic [ByteW-1:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
   endfunction

   // any non-space byte in a command position (re)starts or extends it
   task automatic enter_command(input logic [ByteW-1:0] c);
      phase = LN_COMMAND;
      if (!is_alnum(c)) note_error(ERR_BAD_CMD);
   endtask

   task automatic predict_token(input itk_req_type r, output itk_rsp_type o);
      logic [ByteW-1:0] c;
      logic [5:0]       total;
      logic [ErrW-1:0]  code;
      o = '0;
      c = r.byte_value;
      if (len_count != CountMax) len_count++;
      if (c == CHAR_NUL) saw_nul = 1'b1;

      if (len_count > lim_len || saw_nul || first_err != ERR_NONE) begin
         o.byte_class = CLS_AFTER_ERR;
      end else if (r.last_byte && c == CHAR_CR) begin
         o.byte_class = CLS_CR;
      end else begin
         case (phase)
            LN_LEAD: begin
               if (c == CHAR_SPACE) begin
                  o.byte_class = CLS_SPACE;
               end else if (c == CHAR_COLON) begin
                  o.byte_class = CLS_COLON;
                  phase        = LN_PREFIX;
                  pfx_filled   = 1'b0;
               end else begin
                  o.byte_class = CLS_COMMAND;
                  enter_command(c);
               end
            end
            LN_PREFIX: begin
               if (c == CHAR_SPACE) begin
                  o.byte_class = CLS_SPACE;
                  phase        = LN_AFTER_PREFIX;
                  if (!pfx_filled) note_error(ERR_EMPTY_PFX);
               end else begin
                  o.byte_class = CLS_PREFIX;
                  pfx_filled   = 1'b1;
               end
            end
            LN_AFTER_PREFIX, LN_COMMAND: begin
               if (c == CHAR_SPACE) begin
                  o.byte_class = CLS_SPACE;
                  if (phase == LN_COMMAND) phase = LN_PARAM_GAP;
               end else begin
                  o.byte_class = CLS_COMMAND;
                  enter_command(c);
               end
            end
            LN_PARAM_GAP: begin
               if (c == CHAR_SPACE) begin
                  o.byte_class = CLS_SPACE;
               end else if (c == CHAR_COLON) begin
                  o.byte_class = CLS_COLON;
                  trail_seen   = 1'b1;
                  phase        = LN_TRAILING;
               end else begin
                  // new middle param; index sticks at the saturated count
                  if (started_params == ParSat) param_over = 1'b1;
                  cur_param = started_params;
                  if (started_params != ParSat) started_params++;
                  phase         = LN_MIDDLE;
                  o.byte_class  = CLS_MIDDLE;
                  o.param_index = cur_param;
               end
            end
            LN_MIDDLE: begin
               if (c == CHAR_SPACE) begin
                  o.byte_class = CLS_SPACE;
                  phase        = LN_PARAM_GAP;
               end else begin
                  o.byte_class  = CLS_MIDDLE;
                  o.param_index = cur_param;
               end
            end
            default: begin
               o.byte_class = CLS_TRAILING;
               trail_filled = 1'b1;
            end
         endcase
      end

      if (r.last_byte) begin
         total = {1'b0, started_params} + 6'(trail_filled) + 6'(param_over);
         case (phase)
            LN_LEAD:         note_error(ERR_BLANK);
            LN_PREFIX:       note_error(ERR_PFX_NO_SPACE);
            LN_AFTER_PREFIX: note_error(ERR_EMPTY_CMD);
            LN_COMMAND:      ;
            default:         if (total > {1'b0, lim_params}) note_error(ERR_TOO_MANY);
         endcase
         if (len_count > lim_len) code = ERR_TOO_LONG;
         else if (saw_nul)        code = ERR_NUL;
         else                     code = first_err;
         o.line_done    = 1'b1;
         o.line_valid   = (code == ERR_NONE);
         o.error_code   = code;
         o.param_count  = (total > 6'(ParSat)) ? ParSat : total[ParW-1:0];
         o.has_trailing = trail_seen;
         clear_line_state();
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatches < 100) $display("%0t: result %0d: %s", $time, token_seq, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      itk_rsp_type want;
      if (reset) begin
         lim_len    = MaxLineLengthReset;
         lim_params = MaxParamsReset;
         clear_line_state();
         predicted_tokens.delete();
         token_seq = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_LINE_LENGTH: lim_len    = csr_wdata;
               CSR_MAX_PARAMS:      lim_params = csr_wdata[ParW-1:0];
               default:             ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_token(req_data, want);
            predicted_tokens.insert(predicted_tokens.size(), want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_tokens.size() == 0) begin
               report_mismatch("result with no byte waiting for it");
            end else begin
               want = predicted_tokens.pop_front();
               check_field("byte_class", 16'(rsp_data.byte_class), 16'(want.byte_class));
               check_field("param_index", 16'(rsp_data.param_index),
                           16'(want.param_index));
               check_field("line_done", 16'(rsp_data.line_done), 16'(want.line_done));
               check_field("line_valid", 16'(rsp_data.line_valid), 16'(want.line_valid));
               check_field("error_code", 16'(rsp_data.error_code), 16'(want.error_code));
               check_field("param_count", 16'(rsp_data.param_count),
                           16'(want.param_count));
               check_field("has_trailing", 16'(rsp_data.has_trailing),
                           16'(want.has_trailing));
            end
            token_seq++;
         end
      end
      tokens_waiting = predicted_tokens.size();
   end

endmodule

// ===== tb/tb_irc_line_tokenizer.sv =====
// tb_irc_line_tokenizer: stimulus and verdict for the IRC line tokenizer.
// Depends on itk_pkg, the irc_line_tokenizer RTL and itk_token_checker.
module tb_irc_line_tokenizer;
   import itk_pkg::*;

   localparam int CycleLimit  = 500000;
   localparam int PhaseCount  = 8;
   localparam int PhaseBytes  = 195;  // random bytes per limit setting
   localparam int DrainCycles = 8;    // result path is the queue, then the result register

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   itk_req_type        req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   itk_rsp_type        rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [LenW-1:0]    csr_wdata = '0;

   int mismatches;
   int tokens_waiting;

   // Limit settings per phase: both extremes of each register show up,
   // including a zero length (every line too long) and a length the
   // saturating byte counter can never pass.
   int phase_len    [PhaseCount] = '{8191, 40, 0, 1, 4096, 30, 512, 8190};
   int phase_params [PhaseCount] = '{31, 3, 0, 31, 0, 8, 15, 1};

   // Idle mix, in percent of cycles
   int send_idle_pct = 0;
   int stall_pct     = 0;

   int cycle_count   = 0;
   int bytes_sent    = 0;

   logic [ByteW-1:0] line_buf[$];

   irc_line_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   itk_token_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .tokens_waiting (tokens_waiting)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver side: one stall decision per cycle, made at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Present one item at a falling edge and hold it until taken. Returns at
   // the falling edge after acceptance, with valid still high, so the next
   // call makes exactly one assignment to valid in that step.
   task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{byte_value: b, last_byte: last};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++)
         send_byte(line_buf[i], i == line_buf.size() - 1);
   endtask

   // Drop valid, then wait for every predicted result plus the pipe depth.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tokens_waiting != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limits(input int len, input int params);
      csr_valid <= 1'b1;
      csr_index <= CSR_MAX_LINE_LENGTH;
      csr_wdata <= LenW'(len);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_MAX_PARAMS;
      csr_wdata <= LenW'(params);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ByteW-1:0] alnum_byte();
      case ($urandom_range(2))
         0:       return 8'("A" + $urandom_range(25));
         1:       return 8'("a" + $urandom_range(25));
         default: return 8'("0" + $urandom_range(9));
      endcase
   endfunction

   // Any byte that can sit inside a prefix or middle param (high bytes
   // and a stray CR included); never a space, colon or NUL.
   function automatic logic [ByteW-1:0] token_byte();
      logic [ByteW-1:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CHAR_SPACE || c == CHAR_COLON);
      return c;
   endfunction

   task automatic append_byte(input logic [ByteW-1:0] b);
      line_buf.insert(line_buf.size(), b);
   endtask

   task automatic add_spaces(input int n);
      repeat (n) append_byte(CHAR_SPACE);
   endtask

   task automatic add_token(input int n, input logic alnum);
      repeat (n) append_byte(alnum ? alnum_byte() : token_byte());
   endtask

   // Usually well-formed: [':' prefix SP] command {SP param} [SP ':' text] [CR]
   task automatic build_message();
      int nparams;
      line_buf.delete();
      if ($urandom_range(9) == 0) add_spaces($urandom_range(1, 2));
      if ($urandom_range(9) < 3) begin
         append_byte(CHAR_COLON);
         if ($urandom_range(19) != 0) add_token($urandom_range(1, 6), 1'b0);
         add_spaces($urandom_range(1, 2));
      end
      add_token($urandom_range(1, 5), 1'b1);
      // now and then enough params to saturate the index and count
      nparams = ($urandom_range(19) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 5);
      repeat (nparams) begin
         add_spaces($urandom_range(1, 2));
         add_token($urandom_range(1, 4), 1'b0);
      end
      if ($urandom_range(9) < 4) begin
         add_spaces(1);
         append_byte(CHAR_COLON);
         repeat ($urandom_range(0, 10)) append_byte(8'($urandom_range(1, 255)));
      end else if ($urandom_range(19) == 0) begin
         add_spaces(1);  // ends in the gap between params
      end
      if ($urandom_range(1)) append_byte(CHAR_CR);
   endtask

   initial begin
      int pick;
      // Hold reset, then release it at a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed lines under the reset limits (512 bytes, 15 params)
      line_buf = '{8'h41};                                  // bare command
      send_line();
      line_buf = '{CHAR_CR};                                // blank, CR stripped
      send_line();
      line_buf = '{CHAR_SPACE};                             // blank, spaces only
      send_line();
      line_buf = '{CHAR_COLON, 8'h70};                      // ends inside prefix
      send_line();
      line_buf = '{CHAR_COLON, CHAR_SPACE, 8'h58};          // empty prefix
      send_line();
      line_buf = '{CHAR_COLON, 8'h70, CHAR_SPACE};          // no command
      send_line();
      line_buf = '{8'hFF};                                  // high byte command
      send_line();
      line_buf = '{8'h41, CHAR_NUL};                        // NUL freezes parse
      send_line();
      // empty trailing then a stripped CR
      line_buf = '{8'h41, CHAR_SPACE, 8'h62, CHAR_SPACE, CHAR_COLON, CHAR_CR};
      send_line();
      line_buf = '{8'h41, CHAR_CR, 8'h39};                  // CR mid-command
      send_line();
      line_buf = '{CHAR_SPACE, CHAR_COLON, 8'h70, CHAR_SPACE, 8'h5A};
      send_line();

      for (int p = 0; p < PhaseCount; p++) begin
         wait_drained();
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         write_limits(phase_len[p], phase_params[p]);

         bytes_sent = 0;
         while (bytes_sent < ((phase_len[p] == 0) ? 60 : PhaseBytes)) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
               build_message();
               if (pick >= 70) begin
                  // broken: overwrite a byte or two with anything, NUL included
                  repeat ($urandom_range(1, 2))
                     line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(0, 255));
               end
            end else begin
               line_buf.delete();
               repeat ($urandom_range(1, 10)) begin
                  case ($urandom_range(3))
                     0:       append_byte(CHAR_SPACE);
                     1:       append_byte(CHAR_COLON);
                     2:       append_byte(CHAR_CR);
                     default: append_byte(8'($urandom_range(0, 255)));
                  endcase
               end
            end
            send_line();
         end
      end

      wait_drained();
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
